// File: sv/image_slice_reassembler_macros.svh
// assertion helpers for the slice reassembler checker
`ifndef IMAGE_SLICE_REASSEMBLER_MACROS_SVH
`define IMAGE_SLICE_REASSEMBLER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ISR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ISR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/isr_pkg.sv
package isr_pkg;

	localparam int STORE_BYTES_DEF = 262144;
	localparam int DUP_CHECK_DEF = 32;
	localparam int FILL_BYTE_DEF = 136;
	localparam logic [18:0] MAX_FRAME_RESET = 19'(200 * 1024);
	localparam int CFG_IDX_W = 1;

	localparam logic [1:0] OP_HDR = 2'd0;
	localparam logic [1:0] OP_DATA = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_VIDEO_TYPE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME = 1'd1;

	typedef enum logic [2:0] {
		ST_ACCEPTED = 3'd0,
		ST_OLD = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_TOO_LARGE = 3'd3,
		ST_OTHER_TYPE = 3'd4,
		ST_COMPLETE = 3'd5,
		ST_READ = 3'd6,
		ST_RANGE = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_REFILL,
		S_CHECK,
		S_DUP,
		S_DUPCHK,
		S_RDWAIT
	} state_t;

	typedef struct packed {
		logic hdr;
		logic data;
		logic rd;
		logic rd_emit;
		logic clr_step;
		logic range_emit;
		logic dup_start;
		logic dup_rd;
		logic dup_next;
		logic dup_emit;
		logic accept;
	} cmd_t;

	typedef struct packed {
		logic hdr_reject;
		logic hdr_newer;
		logic rd_ok;
		logic clr_last;
		logic range_bad;
		logic win_empty;
		logic dup_last;
		logic dup_mismatch;
		logic out_free;
	} sts_t;

endpackage

// File: sv/isr_slice_if.sv
interface isr_slice_if;
	logic valid;
	logic ready;
	logic [1:0] opcode;
	logic [7:0] slice_type;
	logic [31:0] frame_seq;
	logic [17:0] slice_offset;
	logic [15:0] slice_len;
	logic [23:0] frame_bytes;
	logic [7:0] data_byte;
	logic [17:0] read_addr;

	modport source (output valid, opcode, slice_type, frame_seq, slice_offset, slice_len,
		frame_bytes, data_byte, read_addr, input ready);
	modport sink (input valid, opcode, slice_type, frame_seq, slice_offset, slice_len,
		frame_bytes, data_byte, read_addr, output ready);
endinterface

// File: sv/isr_result_if.sv
interface isr_result_if;
	import isr_pkg::*;
	logic valid;
	logic ready;
	status_t status;
	logic [18:0] frame_length;
	logic [7:0] read_data;
	logic [31:0] seq_now;

	modport source (output valid, status, frame_length, read_data, seq_now, input ready);
	modport sink (input valid, status, frame_length, read_data, seq_now, output ready);
endinterface

// File: sv/isr_cfg_if.sv
interface isr_cfg_if;
	import isr_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [18:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: sv/isr_ram.sv
module isr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: sv/isr_ctrl.sv
module isr_ctrl (
	input logic clk,
	input logic arst_n,
	input logic slice_valid,
	input logic [1:0] opcode,
	output logic slice_ready,
	output isr_pkg::cmd_t cmd,
	input isr_pkg::sts_t sts
);
	import isr_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		slice_ready = 1'b0;
		case (state_q)
			S_INIT: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				slice_ready = sts.out_free;
				if (slice_valid && sts.out_free) begin
					case (opcode)
						OP_HDR: begin
							cmd.hdr = 1'b1;
							if (!sts.hdr_reject) state_d = sts.hdr_newer ? S_REFILL : S_CHECK;
						end
						OP_DATA: cmd.data = 1'b1;
						OP_READ: begin
							cmd.rd = 1'b1;
							if (sts.rd_ok) state_d = S_RDWAIT;
						end
						default: ;
					endcase
				end
			end
			S_REFILL: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = S_IDLE;
				if (sts.range_bad) begin
					cmd.range_emit = 1'b1;
				end else if (sts.win_empty) begin
					cmd.accept = 1'b1;
				end else begin
					cmd.dup_start = 1'b1;
					state_d = S_DUP;
				end
			end
			S_DUP: begin
				cmd.dup_rd = 1'b1;
				state_d = S_DUPCHK;
			end
			S_DUPCHK: begin
				state_d = S_IDLE;
				if (sts.dup_mismatch) begin
					cmd.dup_emit = 1'b1;
				end else if (sts.dup_last) begin
					cmd.accept = 1'b1;
				end else begin
					cmd.dup_next = 1'b1;
					state_d = S_DUP;
				end
			end
			S_RDWAIT: begin
				cmd.rd_emit = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_INIT;
		endcase
	end
endmodule

// File: sv/isr_datapath.sv
module isr_datapath #(
	parameter int STORE_BYTES = isr_pkg::STORE_BYTES_DEF,
	parameter int DUP_CHECK_BYTES = isr_pkg::DUP_CHECK_DEF,
	parameter int FILL_BYTE = isr_pkg::FILL_BYTE_DEF
) (
	input logic clk,
	input logic arst_n,
	input isr_pkg::cmd_t cmd,
	output isr_pkg::sts_t sts,
	input logic [7:0] slice_type,
	input logic [31:0] frame_seq,
	input logic [17:0] slice_offset,
	input logic [15:0] slice_len,
	input logic [23:0] frame_bytes,
	input logic [7:0] data_byte,
	input logic [17:0] read_addr,
	input logic cfg_valid,
	input logic [isr_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [18:0] cfg_data,
	output logic cfg_ready,
	input logic res_ready,
	output logic res_valid,
	output isr_pkg::status_t res_status,
	output logic [18:0] res_frame_length,
	output logic [7:0] res_read_data,
	output logic [31:0] res_seq_now
);
	import isr_pkg::*;

	localparam int AW = $clog2(STORE_BYTES);
	localparam int DW = (DUP_CHECK_BYTES > 1) ? $clog2(DUP_CHECK_BYTES) : 1;
	localparam logic [20:0] STORE_LIM = 21'(STORE_BYTES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);
	localparam logic [DW-1:0] DUP_LAST = DW'(DUP_CHECK_BYTES - 1);
	localparam logic [7:0] FILL = 8'(FILL_BYTE);

	logic [31:0] cur_seq_q;
	logic [23:0] gathered_q, target_q, fb_q;
	logic [AW-1:0] wptr_q, clr_q;
	logic [15:0] pending_q, len_q;
	logic keep_q;
	logic [6:0] vtype_q;
	logic [18:0] maxf_q;
	logic [17:0] off_q;
	logic [DW-1:0] dup_q;
	logic res_valid_q;
	status_t res_status_q;
	logic [18:0] res_flen_q;
	logic [7:0] res_rdata_q;
	logic [31:0] res_seq_q;

	logic too_big, type_bad, seq_old;
	logic [20:0] dup_addr;
	logic [24:0] sum;
	logic [23:0] sat;
	logic pay_live, pay_write;
	logic emit;
	status_t emit_code;
	logic [18:0] emit_flen;
	logic [7:0] emit_rdata;
	logic ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0] ram_wdata, ram_rdata;

	assign cfg_ready = 1'b1;

	assign too_big = frame_bytes > {5'd0, maxf_q};
	assign type_bad = slice_type[6:0] != vtype_q;
	assign seq_old = frame_seq < cur_seq_q;
	assign dup_addr = {3'd0, off_q} + 21'(dup_q);
	assign sum = {1'b0, gathered_q} + {9'd0, len_q};
	assign sat = sum[24] ? 24'hFFFFFF : sum[23:0];
	assign pay_live = cmd.data && (pending_q != 16'd0);
	assign pay_write = pay_live && keep_q;

	always_comb begin
		sts.hdr_reject = too_big || type_bad || seq_old;
		sts.hdr_newer = frame_seq > cur_seq_q;
		sts.rd_ok = {3'd0, read_addr} < STORE_LIM;
		sts.clr_last = clr_q == LAST_ADDR;
		sts.range_bad = ({3'd0, off_q} + {5'd0, len_q}) > STORE_LIM;
		sts.win_empty = {3'd0, off_q} >= STORE_LIM;
		sts.dup_last = (dup_q == DUP_LAST) || ((dup_addr + 21'd1) >= STORE_LIM);
		sts.dup_mismatch = ram_rdata != FILL;
		sts.out_free = !res_valid_q || res_ready;
	end

	// result selection, at most one command emits per cycle
	always_comb begin
		emit = 1'b0;
		emit_code = ST_ACCEPTED;
		emit_flen = '0;
		emit_rdata = '0;
		if (cmd.hdr && sts.hdr_reject) begin
			emit = 1'b1;
			emit_code = too_big ? ST_TOO_LARGE : (type_bad ? ST_OTHER_TYPE : ST_OLD);
		end
		if (pay_live && keep_q && pending_q == 16'd1 && gathered_q == target_q) begin
			emit = 1'b1;
			emit_code = ST_COMPLETE;
			emit_flen = gathered_q[18:0];
		end
		if ((cmd.rd && !sts.rd_ok) || cmd.range_emit) begin
			emit = 1'b1;
			emit_code = ST_RANGE;
		end
		if (cmd.rd_emit) begin
			emit = 1'b1;
			emit_code = ST_READ;
			emit_rdata = ram_rdata;
		end
		if (cmd.dup_emit) begin
			emit = 1'b1;
			emit_code = ST_DUPLICATE;
		end
		if (cmd.accept) begin
			emit = 1'b1;
			if (len_q == 16'd0 && sat == fb_q) begin
				emit_code = ST_COMPLETE;
				emit_flen = sat[18:0];
			end
		end
	end

	always_comb begin
		ram_we = cmd.clr_step || pay_write;
		ram_waddr = cmd.clr_step ? clr_q : wptr_q;
		ram_wdata = cmd.clr_step ? FILL : data_byte;
		ram_re = cmd.rd || cmd.dup_rd;
		ram_raddr = cmd.dup_rd ? dup_addr[AW-1:0] : AW'(read_addr);
	end

	isr_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_seq_q <= '0;
			gathered_q <= '0;
			target_q <= '0;
			wptr_q <= '0;
			pending_q <= '0;
			keep_q <= 1'b0;
			vtype_q <= '0;
			maxf_q <= MAX_FRAME_RESET;
			clr_q <= '0;
			dup_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_VIDEO_TYPE: vtype_q <= cfg_data[6:0];
					REG_MAX_FRAME: maxf_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.hdr) begin
				pending_q <= slice_len;
				wptr_q <= AW'(slice_offset);
				keep_q <= 1'b0;
				if (!sts.hdr_reject && sts.hdr_newer) begin
					cur_seq_q <= frame_seq;
					gathered_q <= '0;
				end
			end
			if (pay_live) begin
				pending_q <= pending_q - 16'd1;
				if (keep_q) wptr_q <= wptr_q + AW'(1);
				if (pending_q == 16'd1) keep_q <= 1'b0;
			end
			if (cmd.clr_step) clr_q <= sts.clr_last ? '0 : clr_q + AW'(1);
			if (cmd.dup_start) dup_q <= '0;
			if (cmd.dup_next) dup_q <= dup_q + DW'(1);
			if (cmd.accept) begin
				keep_q <= 1'b1;
				target_q <= fb_q;
				gathered_q <= sat;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hdr) begin
			off_q <= slice_offset;
			len_q <= slice_len;
			fb_q <= frame_bytes;
		end
		if (emit) begin
			res_status_q <= emit_code;
			res_flen_q <= emit_flen;
			res_rdata_q <= emit_rdata;
			res_seq_q <= cur_seq_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_status = res_status_q;
	assign res_frame_length = res_flen_q;
	assign res_read_data = res_rdata_q;
	assign res_seq_now = res_seq_q;
endmodule

// File: sv/image_slice_reassembler.sv
// image slice reassembler: rebuilds frames from slices in a byte store
// slice_ch takes transactions: slice header, payload byte, or read of a stored byte
// result_ch returns at most one status transaction per input transaction, in order
// cfg_ch writes video_type (index 0) and max_frame_bytes (index 1), always ready
// payload bytes and rejected headers are handled without leaving the idle state
// an in-range read of the store waits in S_RDWAIT (one store read port, registered data)
// an accepted header checks its duplicate window byte by byte,
//   through S_DUP and S_DUPCHK per byte, up to DUP_CHECK_BYTES bytes
// a header with a newer sequence first refills the whole store with the fill byte
// after reset the same fill pass runs over the whole store before the first
//   slice transaction is taken; config writes are taken during it
// one transaction is in work at a time; the result sits in an output register
// a stalled receiver holds the result and slice_ch.ready stays low until it drains
module image_slice_reassembler #(
	parameter int STORE_BYTES = isr_pkg::STORE_BYTES_DEF,
	parameter int DUP_CHECK_BYTES = isr_pkg::DUP_CHECK_DEF,
	parameter int FILL_BYTE = isr_pkg::FILL_BYTE_DEF
) (
	input logic clk,
	input logic arst_n,
	isr_slice_if.sink slice_ch,
	isr_result_if.source result_ch,
	isr_cfg_if.sink cfg_ch
);
	import isr_pkg::*;

	// control handoff between sequencer and datapath
	cmd_t cmd;
	sts_t sts;

	isr_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.slice_valid(slice_ch.valid),
		.opcode(slice_ch.opcode),
		.slice_ready(slice_ch.ready),
		.cmd(cmd),
		.sts(sts)
	);

	// store, frame counters, config registers and output register
	isr_datapath #(
		.STORE_BYTES(STORE_BYTES),
		.DUP_CHECK_BYTES(DUP_CHECK_BYTES),
		.FILL_BYTE(FILL_BYTE)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.slice_type(slice_ch.slice_type),
		.frame_seq(slice_ch.frame_seq),
		.slice_offset(slice_ch.slice_offset),
		.slice_len(slice_ch.slice_len),
		.frame_bytes(slice_ch.frame_bytes),
		.data_byte(slice_ch.data_byte),
		.read_addr(slice_ch.read_addr),
		.cfg_valid(cfg_ch.valid),
		.cfg_index(cfg_ch.index),
		.cfg_data(cfg_ch.data),
		.cfg_ready(cfg_ch.ready),
		.res_ready(result_ch.ready),
		.res_valid(result_ch.valid),
		.res_status(result_ch.status),
		.res_frame_length(result_ch.frame_length),
		.res_read_data(result_ch.read_data),
		.res_seq_now(result_ch.seq_now)
	);
endmodule

// File: sv/isr_checker.sv
`include "image_slice_reassembler_macros.svh"

module isr_checker (
	input logic clk,
	input logic arst_n,
	input logic slice_valid,
	input logic slice_ready,
	input logic result_valid,
	input logic result_ready,
	input logic [2:0] result_status,
	input logic [18:0] result_frame_length,
	input logic [7:0] result_read_data,
	input logic [31:0] result_seq_now
);
	import isr_pkg::*;

	logic res_stall, not_complete, not_read;

	assign res_stall = result_valid && !result_ready;
	assign not_complete = result_status != ST_COMPLETE;
	assign not_read = result_status != ST_READ;

	`ISR_ASSERT_NXT(a_res_hold, res_stall, result_valid && $stable(result_status) && $stable(result_seq_now), "stalled result changed")
	`ISR_ASSERT_IMP(a_len_zero, result_valid && not_complete, result_frame_length == 19'd0, "frame length set on non-complete result")
	`ISR_ASSERT_IMP(a_rdata_zero, result_valid && not_read, result_read_data == 8'd0, "read data set on non-read result")
	`ISR_ASSERT_IMP(a_no_take_on_stall, slice_valid && slice_ready, !res_stall, "slice taken while result stalled")
endmodule

bind image_slice_reassembler isr_checker u_isr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.slice_valid(slice_ch.valid),
	.slice_ready(slice_ch.ready),
	.result_valid(result_ch.valid),
	.result_ready(result_ch.ready),
	.result_status(result_ch.status),
	.result_frame_length(result_ch.frame_length),
	.result_read_data(result_ch.read_data),
	.result_seq_now(result_ch.seq_now)
);
